@@ design/ffaa_pkg.sv @@
// ----------------------------------------------------------------------------
// ffaa_pkg
// shared constants, block record type and size compare for the arena allocator
// ----------------------------------------------------------------------------
package ffaa_pkg;

  localparam int ALIGN_BYTES        = 64;
  localparam int ALIGN_SHIFT        = $clog2(ALIGN_BYTES);
  localparam int ARENA_UNITS        = 4096;
  localparam int IDX_W              = $clog2(ARENA_UNITS);
  localparam int ARENA_HEADER_BYTES = 128;
  localparam int HDR_UNITS          = (ARENA_HEADER_BYTES + ALIGN_BYTES - 1) / ALIGN_BYTES;
  localparam int CACHE_SLOTS        = 7;
  localparam int SLOT_W             = 3;
  localparam logic [SLOT_W-1:0] SLOT_NONE = 3'd7;
  localparam int BYTES_W            = 19;
  localparam int OFF_W              = 18;
  localparam int MAX_BYTES          = ARENA_UNITS * ALIGN_BYTES;
  localparam int RESET_ARENA_BYTES  = 262144;
  localparam int CW                 =
    ((IDX_W + ALIGN_SHIFT > BYTES_W) ? IDX_W + ALIGN_SHIFT : BYTES_W) + 1;
  localparam int PADDR_W            = 3;
  localparam logic REG_ARENA_BYTES  = 1'b0;

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  typedef struct packed {
    logic [IDX_W-1:0]  size;
    logic              active;
    logic              live;
    logic              pv;
    logic [IDX_W-1:0]  prev;
    logic              nv;
    logic [IDX_W-1:0]  next;
    logic [SLOT_W-1:0] slot;
  } blk_t;

  localparam int BLK_W = $bits(blk_t);

  function automatic logic fits(input logic [IDX_W-1:0] s, input logic [BYTES_W-1:0] r);
    logic [CW-1:0] t;
    t = CW'(s) << ALIGN_SHIFT;
    return t >= CW'(r);
  endfunction

endpackage

@@ design/ffaa_req_if.sv @@
// ----------------------------------------------------------------------------
// ffaa_req_if
// request channel: operation, size and address with valid/ready
// ----------------------------------------------------------------------------
interface ffaa_req_if;
  logic        valid;
  logic        ready;
  logic        op;
  logic [18:0] size_bytes;
  logic [17:0] address;

  modport source (output valid, output op, output size_bytes, output address, input ready);
  modport sink   (input valid, input op, input size_bytes, input address, output ready);
endinterface

@@ design/ffaa_rsp_if.sv @@
// ----------------------------------------------------------------------------
// ffaa_rsp_if
// result channel: data offset and fail flag with valid/ready
// ----------------------------------------------------------------------------
interface ffaa_rsp_if;
  logic        valid;
  logic        ready;
  logic [17:0] data_offset;
  logic        failed;

  modport source (output valid, output data_offset, output failed, input ready);
  modport sink   (input valid, input data_offset, input failed, output ready);
endinterface

@@ design/ffaa_ram.sv @@
// ----------------------------------------------------------------------------
// ffaa_ram
// generic single write port, single read port ram with registered read
// ----------------------------------------------------------------------------
module ffaa_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;
endmodule

@@ design/first_fit_arena_allocator.sv @@
// ----------------------------------------------------------------------------
// first_fit_arena_allocator
// a free reads the block and merges it with free neighbours; an allocate takes a cached free
// block on a hit, else walks the block list from the first block, up to ARENA_UNITS blocks
// one request at a time, bounded by the single read port of the block ram
// reset and every arena size write start a clearing pass over all ARENA_UNITS blocks,
// during which no request is taken
// ----------------------------------------------------------------------------
module first_fit_arena_allocator (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  ffaa_req_if.sink                    req_i,
  ffaa_rsp_if.source                  rsp_o,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [ffaa_pkg::PADDR_W-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);
  import ffaa_pkg::*;

  localparam logic [3:0] S_CLR   = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_START = 4'd2;
  localparam logic [3:0] S_A_W   = 4'd3;
  localparam logic [3:0] S_A_F   = 4'd4;
  localparam logic [3:0] S_A_SPL = 4'd5;
  localparam logic [3:0] S_WRB   = 4'd6;
  localparam logic [3:0] S_F_B   = 4'd7;
  localparam logic [3:0] S_F_P   = 4'd8;
  localparam logic [3:0] S_F_NX  = 4'd9;
  localparam logic [3:0] S_F_N   = 4'd10;
  localparam logic [3:0] S_MERGE = 4'd11;
  localparam logic [3:0] S_MB    = 4'd12;
  localparam logic [3:0] S_LINK  = 4'd13;
  localparam logic [3:0] S_DONE  = 4'd14;

  logic [3:0] state_q, state_d, ret_q, ret_d;
  logic [IDX_W-1:0] clr_q, clr_d, cnt_q, cnt_d;
  logic [IDX_W-1:0] ia_q, ia_d, ib_q, ib_d, tg_q, tg_d, lk_q, lk_d;
  blk_t wa_q, wa_d, wb_q, wb_d;
  logic op_q, op_d;
  logic [BYTES_W-1:0] sz_q, sz_d;
  logic [OFF_W-1:0] addr_q, addr_d, off_q, off_d, od_q, od_d;
  logic fail_q, fail_d, of_q, of_d, ov_q, ov_d;
  logic [BYTES_W-1:0] arena_q, arena_d;
  logic ok_q, ok_d;
  logic [IDX_W-1:0]  cidx_q [8];
  logic [IDX_W-1:0]  cidx_d [8];
  logic [IDX_W-1:0]  csize_q [8];
  logic [IDX_W-1:0]  csize_d [8];
  logic [SLOT_W-1:0] cur_q, cur_d;

  logic ram_we, ram_re;
  logic [IDX_W-1:0] ram_waddr, ram_raddr;
  blk_t ram_wdata, rd_w;
  logic [BLK_W-1:0] ram_rdata;

  logic cfg_wr;
  logic [BYTES_W:0] byc;
  logic [BYTES_W:0] units_c;
  logic ok_c;
  logic [IDX_W-1:0] size0_c;
  blk_t init_w, empty_w;

  logic hit;
  logic [SLOT_W-1:0] hs;

  logic [CW-1:0] tot, rem, ufull;
  logic lt, split;
  logic [IDX_W-1:0] u_c, n_c;
  logic [IDX_W+ALIGN_SHIFT:0] ow;
  logic [OFF_W-1:0] bq;
  logic addr_ok;

  ffaa_ram #(.Width(BLK_W), .Depth(ARENA_UNITS)) u_ffaa_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign rd_w   = blk_t'(ram_rdata);
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_ARENA_BYTES) ? 32'(arena_q) : 32'd0;
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_ARENA_BYTES);

  assign req_i.ready       = (state_q == S_IDLE);
  assign rsp_o.valid       = ov_q;
  assign rsp_o.data_offset = od_q;
  assign rsp_o.failed      = of_q;

  // init values from the arena size
  always_comb begin
    byc     = (20'(arena_q) > 20'(MAX_BYTES)) ? 20'(MAX_BYTES) : 20'(arena_q);
    units_c = byc >> ALIGN_SHIFT;
    ok_c    = units_c > 20'(HDR_UNITS + 1);
    size0_c = IDX_W'(units_c - 20'(HDR_UNITS) - 20'd1);
    empty_w = '0;
    empty_w.slot = SLOT_NONE;
    init_w  = '0;
    init_w.live = 1'b1;
    init_w.size = size0_c;
    init_w.slot = '0;
  end

  // cache scan, lowest slot wins
  always_comb begin
    hit = 1'b0;
    hs  = '0;
    for (int i = CACHE_SLOTS - 1; i >= 0; i--) begin
      if (csize_q[i] != '0 && fits(csize_q[i], sz_q)) begin
        hit = 1'b1;
        hs  = SLOT_W'(i);
      end
    end
  end

  // split arithmetic and offsets
  always_comb begin
    tot   = CW'(wa_q.size) << ALIGN_SHIFT;
    lt    = tot < CW'(sz_q);
    rem   = tot - CW'(sz_q);
    split = lt || (rem >= CW'(2 * ALIGN_BYTES));
    ufull = (CW'(sz_q) + CW'(ALIGN_BYTES - 1)) >> ALIGN_SHIFT;
    u_c   = ufull[IDX_W-1:0];
    n_c   = ia_q + IDX_W'(1) + u_c;
    ow    = ((IDX_W+ALIGN_SHIFT+1)'(ia_q) + 1'b1) << ALIGN_SHIFT;
    bq    = OFF_W'(addr_q >> ALIGN_SHIFT) - OFF_W'(1);
    addr_ok = (addr_q[ALIGN_SHIFT-1:0] == '0) && (addr_q[OFF_W-1:ALIGN_SHIFT] != '0) &&
              (bq < OFF_W'(ARENA_UNITS));
  end

  always_comb begin
    logic [SLOT_W-1:0] sa, sb;
    logic va, vb;
    logic [IDX_W-1:0] msz, cz;
    blk_t w;
    state_d = state_q;
    ret_d   = ret_q;
    clr_d   = clr_q;
    cnt_d   = cnt_q;
    ia_d    = ia_q;
    ib_d    = ib_q;
    tg_d    = tg_q;
    lk_d    = lk_q;
    wa_d    = wa_q;
    wb_d    = wb_q;
    op_d    = op_q;
    sz_d    = sz_q;
    addr_d  = addr_q;
    off_d   = off_q;
    fail_d  = fail_q;
    od_d    = od_q;
    of_d    = of_q;
    ov_d    = ov_q && !rsp_o.ready;
    arena_d = arena_q;
    ok_d    = ok_q;
    cidx_d  = cidx_q;
    csize_d = csize_q;
    cur_d   = cur_q;
    ram_we    = 1'b0;
    ram_waddr = '0;
    ram_wdata = empty_w;
    ram_re    = 1'b0;
    ram_raddr = '0;
    sa = wa_q.slot;
    sb = wb_q.slot;
    va = (sa < SLOT_W'(CACHE_SLOTS)) && (cidx_q[sa] == ia_q);
    vb = (sb < SLOT_W'(CACHE_SLOTS)) && (cidx_q[sb] == ib_q);
    msz = wa_q.size + wb_q.size + IDX_W'(1);
    cz  = '0;
    w   = rd_w;

    case (state_q)
      S_CLR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_q;
        ram_wdata = (clr_q == IDX_W'(HDR_UNITS) && ok_c) ? init_w : empty_w;
        if (clr_q == '0) begin
          for (int i = 0; i < 8; i++) begin
            cidx_d[i]  = '0;
            csize_d[i] = '0;
          end
          cidx_d[0]  = ok_c ? IDX_W'(HDR_UNITS) : '0;
          csize_d[0] = ok_c ? size0_c : '0;
          cur_d      = SLOT_W'(1 % CACHE_SLOTS);
          ok_d       = ok_c;
        end
        clr_d = clr_q + IDX_W'(1);
        if (clr_q == IDX_W'(ARENA_UNITS - 1)) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (req_i.valid) begin
          op_d    = req_i.op;
          sz_d    = req_i.size_bytes;
          addr_d  = req_i.address;
          state_d = S_START;
        end
      end
      S_START: begin
        off_d  = '0;
        fail_d = 1'b0;
        if (op_q == OP_FREE) begin
          if (addr_ok) begin
            ia_d      = bq[IDX_W-1:0];
            ram_re    = 1'b1;
            ram_raddr = bq[IDX_W-1:0];
            state_d   = S_F_B;
          end else begin
            state_d = S_DONE;
          end
        end else if (hit) begin
          ia_d      = cidx_q[hs];
          ram_re    = 1'b1;
          ram_raddr = cidx_q[hs];
          state_d   = S_A_F;
        end else if (!ok_q) begin
          fail_d  = 1'b1;
          state_d = S_DONE;
        end else begin
          ia_d      = IDX_W'(HDR_UNITS);
          cnt_d     = '0;
          ram_re    = 1'b1;
          ram_raddr = IDX_W'(HDR_UNITS);
          state_d   = S_A_W;
        end
      end
      S_A_W: begin
        if (!rd_w.active && fits(rd_w.size, sz_q)) begin
          wa_d    = rd_w;
          state_d = S_A_SPL;
        end else if (!rd_w.nv || cnt_q == IDX_W'(ARENA_UNITS - 1)) begin
          fail_d  = 1'b1;
          state_d = S_DONE;
        end else begin
          ia_d      = rd_w.next;
          cnt_d     = cnt_q + IDX_W'(1);
          ram_re    = 1'b1;
          ram_raddr = rd_w.next;
        end
      end
      S_A_F: begin
        wa_d    = rd_w;
        state_d = S_A_SPL;
      end
      S_A_SPL: begin
        off_d = ow[OFF_W-1:0];
        w = wa_q;
        w.active = 1'b1;
        w.slot   = SLOT_NONE;
        if (split) begin
          wb_d        = '0;
          wb_d.live   = 1'b1;
          wb_d.pv     = 1'b1;
          wb_d.prev   = ia_q;
          wb_d.nv     = wa_q.nv;
          wb_d.next   = wa_q.next;
          wb_d.size   = wa_q.size - u_c - IDX_W'(1);
          wb_d.slot   = va ? sa : SLOT_NONE;
          ib_d        = n_c;
          w.size      = u_c;
          w.next      = n_c;
          w.nv        = 1'b1;
          if (va) begin
            cidx_d[sa]  = n_c;
            csize_d[sa] = wa_q.size - u_c - IDX_W'(1);
          end
          state_d = S_WRB;
        end else begin
          if (va) begin
            csize_d[sa] = '0;
            if (cur_q != sa && csize_q[cur_q] != '0) begin
              cur_d = sa;
            end
          end
          state_d = S_DONE;
        end
        ram_we    = 1'b1;
        ram_waddr = ia_q;
        ram_wdata = w;
      end
      S_WRB: begin
        ram_we    = 1'b1;
        ram_waddr = ib_q;
        ram_wdata = wb_q;
        if (wb_q.nv) begin
          ram_re    = 1'b1;
          ram_raddr = wb_q.next;
          tg_d      = wb_q.next;
          lk_d      = ib_q;
          ret_d     = S_DONE;
          state_d   = S_LINK;
        end else begin
          state_d = S_DONE;
        end
      end
      S_F_B: begin
        if (!rd_w.live || !rd_w.active) begin
          state_d = S_DONE;
        end else begin
          w.active = 1'b0;
          w.slot   = cur_q;
          cidx_d[cur_q]  = ia_q;
          csize_d[cur_q] = rd_w.size;
          cur_d = (cur_q == SLOT_W'(CACHE_SLOTS - 1)) ? '0 : cur_q + SLOT_W'(1);
          ram_we    = 1'b1;
          ram_waddr = ia_q;
          ram_wdata = w;
          wa_d      = w;
          if (rd_w.pv) begin
            ram_re    = 1'b1;
            ram_raddr = rd_w.prev;
            state_d   = S_F_P;
          end else begin
            state_d = S_F_NX;
          end
        end
      end
      S_F_P: begin
        if (!rd_w.active) begin
          wa_d    = rd_w;
          ia_d    = wa_q.prev;
          wb_d    = wa_q;
          ib_d    = ia_q;
          ret_d   = S_F_NX;
          state_d = S_MERGE;
        end else begin
          state_d = S_F_NX;
        end
      end
      S_F_NX: begin
        if (wa_q.nv) begin
          ram_re    = 1'b1;
          ram_raddr = wa_q.next;
          state_d   = S_F_N;
        end else begin
          state_d = S_DONE;
        end
      end
      S_F_N: begin
        if (!rd_w.active) begin
          wb_d    = rd_w;
          ib_d    = wa_q.next;
          ret_d   = S_DONE;
          state_d = S_MERGE;
        end else begin
          state_d = S_DONE;
        end
      end
      S_MERGE: begin
        w = wa_q;
        w.size = msz;
        w.next = wb_q.next;
        w.nv   = wb_q.nv;
        w.slot = va ? sa : SLOT_NONE;
        if (va) begin
          csize_d[sa] = msz;
        end
        if (vb) begin
          csize_d[sb] = '0;
          if (cur_q == sb) begin
            cz = '0;
          end else if (va && cur_q == sa) begin
            cz = msz;
          end else begin
            cz = csize_q[cur_q];
          end
          if (cz != '0) begin
            cur_d = sb;
          end
        end
        ram_we    = 1'b1;
        ram_waddr = ia_q;
        ram_wdata = w;
        wa_d      = w;
        state_d   = S_MB;
      end
      S_MB: begin
        w = wb_q;
        w.live = 1'b0;
        w.slot = SLOT_NONE;
        ram_we    = 1'b1;
        ram_waddr = ib_q;
        ram_wdata = w;
        if (wa_q.nv) begin
          ram_re    = 1'b1;
          ram_raddr = wa_q.next;
          tg_d      = wa_q.next;
          lk_d      = ia_q;
          state_d   = S_LINK;
        end else begin
          state_d = ret_q;
        end
      end
      S_LINK: begin
        w.prev    = lk_q;
        ram_we    = 1'b1;
        ram_waddr = tg_q;
        ram_wdata = w;
        state_d   = ret_q;
      end
      S_DONE: begin
        if (!ov_q || rsp_o.ready) begin
          ov_d    = 1'b1;
          od_d    = off_q;
          of_d    = fail_q;
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    if (cfg_wr) begin
      arena_d = pwdata[BYTES_W-1:0];
      clr_d   = '0;
      state_d = S_CLR;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLR;
      clr_q   <= '0;
      ret_q   <= S_IDLE;
      ov_q    <= 1'b0;
      arena_q <= BYTES_W'(RESET_ARENA_BYTES);
      ok_q    <= 1'b0;
      cur_q   <= '0;
      for (int i = 0; i < 8; i++) begin
        cidx_q[i]  <= '0;
        csize_q[i] <= '0;
      end
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      ret_q   <= ret_d;
      ov_q    <= ov_d;
      arena_q <= arena_d;
      ok_q    <= ok_d;
      cur_q   <= cur_d;
      cidx_q  <= cidx_d;
      csize_q <= csize_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cnt_q  <= cnt_d;
    ia_q   <= ia_d;
    ib_q   <= ib_d;
    tg_q   <= tg_d;
    lk_q   <= lk_d;
    wa_q   <= wa_d;
    wb_q   <= wb_d;
    op_q   <= op_d;
    sz_q   <= sz_d;
    addr_q <= addr_d;
    off_q  <= off_d;
    fail_q <= fail_d;
    od_q   <= od_d;
    of_q   <= of_d;
  end
endmodule

@@ design/ffaa_checker.sv @@
// ----------------------------------------------------------------------------
// ffaa_checker
// port level checks for the arena allocator, bound to the top level
// ----------------------------------------------------------------------------
module ffaa_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        req_valid_i,
  input logic        req_ready_i,
  input logic        rsp_valid_i,
  input logic        rsp_ready_i,
  input logic [17:0] data_offset_i,
  input logic        failed_i
);
  import ffaa_pkg::*;

  // stalled result holds
  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=> rsp_valid_i && $stable(data_offset_i) && $stable(failed_i))
    else $error("result changed while stalled");

  // one request at a time
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_valid_i && req_ready_i |=> !req_ready_i)
    else $error("ready right after a request");

  // failed result carries no offset
  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && failed_i |-> data_offset_i == '0)
    else $error("failed result with offset");

  // offsets are unit aligned
  a_aligned: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i |-> data_offset_i[ALIGN_SHIFT-1:0] == '0)
    else $error("unaligned offset");
endmodule

bind first_fit_arena_allocator ffaa_checker u_ffaa_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .req_valid_i   (req_i.valid),
  .req_ready_i   (req_i.ready),
  .rsp_valid_i   (rsp_o.valid),
  .rsp_ready_i   (rsp_o.ready),
  .data_offset_i (rsp_o.data_offset),
  .failed_i      (rsp_o.failed)
);

@@ dv/first_fit_arena_allocator_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// first_fit_arena_allocator_tb
// self-checking bench for the arena allocator: a behavioral model of the
// block list and free cache predicts every result, requests are allocate and
// free mixes with random gaps and back pressure, over several arena sizes
// ----------------------------------------------------------------------------
module first_fit_arena_allocator_tb;
  import ffaa_pkg::*;

  typedef struct packed {
    logic        op;
    logic [18:0] size_bytes;
    logic [17:0] address;
  } request_t;

  typedef struct packed {
    logic [17:0] data_offset;
    logic        failed;
  } result_t;

  localparam int LIMIT_CYCLES = 20000000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [PADDR_W-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  ffaa_req_if req_bus ();
  ffaa_rsp_if rsp_bus ();

  first_fit_arena_allocator uut (
    .clk_i(clk_i), .rst_ni(rst_ni), .req_i(req_bus.sink), .rsp_o(rsp_bus.source),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // shadow of the arena
  int unsigned m_arena_bytes;
  int unsigned m_size [ARENA_UNITS];
  bit          m_active [ARENA_UNITS];
  bit          m_live [ARENA_UNITS];
  int unsigned m_prev [ARENA_UNITS];
  bit          m_pv [ARENA_UNITS];
  int unsigned m_next [ARENA_UNITS];
  bit          m_nv [ARENA_UNITS];
  int unsigned m_slot [ARENA_UNITS];
  int unsigned c_idx [CACHE_SLOTS];
  int unsigned c_size [CACHE_SLOTS];
  int unsigned c_cursor;
  bit          arena_usable;
  int unsigned live_offsets [$];

  request_t pending_requests [$];
  result_t  expected_results [$];
  int unsigned errors = 0, cycle_count = 0, results_seen = 0, fails_seen = 0;
  bit hold_rsp = 1'b0;
  bit feed_done = 1'b0;

  function automatic void arena_init();
    int unsigned units, bytes;
    bytes = m_arena_bytes;
    for (int i = 0; i < ARENA_UNITS; i++) begin
      m_size[i] = 0; m_active[i] = 0; m_live[i] = 0; m_prev[i] = 0;
      m_pv[i] = 0; m_next[i] = 0; m_nv[i] = 0; m_slot[i] = SLOT_NONE;
    end
    for (int i = 0; i < CACHE_SLOTS; i++) begin
      c_idx[i] = 0; c_size[i] = 0;
    end
    c_cursor = 1 % CACHE_SLOTS;
    live_offsets.delete();
    if (bytes > MAX_BYTES) bytes = MAX_BYTES;
    units = bytes / ALIGN_BYTES;
    arena_usable = units > HDR_UNITS + 1;
    if (!arena_usable) return;
    m_live[HDR_UNITS] = 1;
    m_size[HDR_UNITS] = units - HDR_UNITS - 1;
    m_slot[HDR_UNITS] = 0;
    c_idx[0] = HDR_UNITS;
    c_size[0] = units - HDR_UNITS - 1;
  endfunction

  function automatic bit slot_holds(int unsigned b);
    int unsigned s;
    s = m_slot[b];
    if (s >= CACHE_SLOTS || c_idx[s] != b) begin
      m_slot[b] = SLOT_NONE;
      return 0;
    end
    return 1;
  endfunction

  function automatic void uncache(int unsigned b);
    int unsigned s;
    if (slot_holds(b)) begin
      s = m_slot[b];
      c_size[s] = 0;
      if (c_size[c_cursor] != 0) c_cursor = s;
      m_slot[b] = SLOT_NONE;
    end
  endfunction

  function automatic void coalesce(int unsigned a, int unsigned b);
    m_size[a] += m_size[b] + 1;
    m_next[a] = m_next[b];
    m_nv[a] = m_nv[b];
    if (m_nv[a]) m_prev[m_next[a] % ARENA_UNITS] = a;
    if (slot_holds(a)) c_size[m_slot[a]] = m_size[a];
    uncache(b);
    m_live[b] = 0;
  endfunction

  function automatic result_t arena_apply(request_t r);
    result_t res;
    int unsigned f, b, s, u, n, req;
    bit hit;
    res = '0;
    req = r.size_bytes;
    if (r.op == OP_FREE) begin
      if (r.address % ALIGN_BYTES != 0 || r.address < ALIGN_BYTES) return res;
      b = r.address / ALIGN_BYTES - 1;
      if (b >= ARENA_UNITS || !m_live[b] || !m_active[b]) return res;
      m_active[b] = 0;
      s = c_cursor % CACHE_SLOTS;
      c_idx[s] = b; c_size[s] = m_size[b]; m_slot[b] = s;
      c_cursor = (s + 1) % CACHE_SLOTS;
      if (m_pv[b] && !m_active[m_prev[b] % ARENA_UNITS]) begin
        coalesce(m_prev[b] % ARENA_UNITS, b);
        b = m_prev[b] % ARENA_UNITS;
      end
      if (m_nv[b] && !m_active[m_next[b] % ARENA_UNITS]) coalesce(b, m_next[b] % ARENA_UNITS);
      return res;
    end
    hit = 0;
    for (int i = 0; i < CACHE_SLOTS && !hit; i++)
      if (c_size[i] != 0 && c_size[i] * ALIGN_BYTES >= req) begin
        f = c_idx[i] % ARENA_UNITS; hit = 1;
      end
    if (!hit && arena_usable) begin
      b = HDR_UNITS;
      for (int k = 0; k < ARENA_UNITS && !hit; k++) begin
        if (!m_active[b] && m_size[b] * ALIGN_BYTES >= req) begin
          f = b; hit = 1;
        end else if (!m_nv[b]) begin
          break;
        end else begin
          b = m_next[b] % ARENA_UNITS;
        end
      end
    end
    if (!hit) begin
      res.failed = 1'b1;
      return res;
    end
    m_active[f] = 1;
    if (m_size[f] * ALIGN_BYTES - req >= 2 * ALIGN_BYTES) begin
      u = (req + ALIGN_BYTES - 1) / ALIGN_BYTES;
      n = (f + 1 + u) % ARENA_UNITS;
      m_live[n] = 1; m_active[n] = 0; m_prev[n] = f; m_pv[n] = 1;
      m_next[n] = m_next[f]; m_nv[n] = m_nv[f];
      if (m_nv[n]) m_prev[m_next[n] % ARENA_UNITS] = n;
      m_size[n] = m_size[f] - u - 1;
      m_slot[n] = SLOT_NONE;
      m_size[f] = u;
      m_next[f] = n; m_nv[f] = 1;
      if (slot_holds(f)) begin
        s = m_slot[f];
        c_idx[s] = n; c_size[s] = m_size[n]; m_slot[n] = s; m_slot[f] = SLOT_NONE;
      end
    end else begin
      uncache(f);
    end
    res.data_offset = 18'(((f + 1) * ALIGN_BYTES) & 32'h3FFFF);
    return res;
  endfunction

  // random gap: mostly short, a few long
  function automatic int unsigned gap_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 40) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // request driver
  int unsigned send_gap = 0;
  int unsigned sent_n = 0, taken_n = 0;
  always @(negedge clk_i) begin
    if (req_bus.valid && req_bus.ready) begin
    end
  end

  request_t cur_req;
  always @(posedge clk_i) begin
    if (!rst_ni) begin
    end else if (req_bus.valid && req_bus.ready) begin
      taken_n <= taken_n + 1;
      expected_results.push_back(arena_apply(cur_req));
    end
  end

  always @(negedge clk_i) begin
    if (!rst_ni) begin
      req_bus.valid <= 1'b0;
    end else if (req_bus.valid && sent_n != taken_n) begin
    end else if (send_gap != 0) begin
      send_gap <= send_gap - 1;
      req_bus.valid <= 1'b0;
    end else if (pending_requests.size() != 0) begin
      cur_req = pending_requests.pop_front();
      req_bus.valid <= 1'b1;
      req_bus.op <= cur_req.op;
      req_bus.size_bytes <= cur_req.size_bytes;
      req_bus.address <= cur_req.address;
      sent_n <= sent_n + 1;
      send_gap <= gap_len();
    end else begin
      req_bus.valid <= 1'b0;
    end
  end

  // result monitor and stall generator
  int unsigned rsp_gap = 0;
  always @(negedge clk_i) begin
    if (hold_rsp) begin
      rsp_bus.ready <= 1'b0;
    end else if (rsp_gap != 0) begin
      rsp_gap <= rsp_gap - 1;
      rsp_bus.ready <= 1'b0;
    end else begin
      rsp_bus.ready <= 1'b1;
      rsp_gap <= gap_len();
    end
  end

  always @(posedge clk_i) begin
    result_t exp_r;
    cycle_count <= cycle_count + 1;
    if (rst_ni && rsp_bus.valid && rsp_bus.ready) begin
      results_seen <= results_seen + 1;
      if (expected_results.size() == 0) begin
        errors <= errors + 1;
        $error("result with no pending request: offset %0h", rsp_bus.data_offset);
      end else begin
        exp_r = expected_results.pop_front();
        if (exp_r.failed) fails_seen <= fails_seen + 1;
        if (rsp_bus.data_offset !== exp_r.data_offset) begin
          errors <= errors + 1;
          $error("data_offset: expected %0h, got %0h", exp_r.data_offset, rsp_bus.data_offset);
        end
        if (rsp_bus.failed !== exp_r.failed) begin
          errors <= errors + 1;
          $error("failed: expected %0b, got %0b", exp_r.failed, rsp_bus.failed);
        end
      end
    end
    if (cycle_count > LIMIT_CYCLES) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin
    req_bus.valid = 1'b0;
    req_bus.op = OP_ALLOC;
    req_bus.size_bytes = '0;
    req_bus.address = '0;
    rsp_bus.ready = 1'b0;
  end

  function automatic request_t alloc_req(int unsigned sz);
    request_t r;
    r.op = OP_ALLOC; r.size_bytes = 19'(sz); r.address = 18'($urandom);
    return r;
  endfunction

  function automatic request_t free_req(int unsigned addr);
    request_t r;
    r.op = OP_FREE; r.size_bytes = 19'($urandom); r.address = 18'(addr);
    return r;
  endfunction

  // sizes kept small so the arena sees many blocks; a few large ones too
  function automatic request_t random_request(int unsigned max_sz);
    int unsigned r, pick;
    r = $urandom_range(0, 99);
    if (r < 50) return alloc_req($urandom_range(0, max_sz));
    if (r < 53) return alloc_req($urandom_range(0, 19'h7FFFF));
    if (r < 90) return free_req((($urandom_range(0, 160) + 1) * ALIGN_BYTES));
    if (r < 95) return free_req($urandom_range(0, 18'h3FFFF));
    pick = $urandom_range(0, 3);
    return free_req(pick * ALIGN_BYTES + $urandom_range(0, 1));
  endfunction

  task automatic drain();
    while (pending_requests.size() != 0 || expected_results.size() != 0 || req_bus.valid)
      @(posedge clk_i);
    repeat (40) @(posedge clk_i);
  endtask

  task automatic write_arena(int unsigned val);
    @(negedge clk_i);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= PADDR_W'(REG_ARENA_BYTES); pwdata <= val;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    m_arena_bytes = val & 32'h7FFFF;
    arena_init();
    @(negedge clk_i);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
  endtask

  task automatic run_random(int unsigned count, int unsigned max_sz);
    repeat (count) pending_requests.push_back(random_request(max_sz));
    drain();
  endtask

  int unsigned arena_settings [5] = '{19'h7FFFF, 0, 256, 8192, 262144};

  initial begin
    m_arena_bytes = RESET_ARENA_BYTES;
    arena_init();
    repeat (3) @(posedge clk_i);
    @(negedge clk_i) rst_ni = 1'b1;

    // directed: extremes, zero size, bad frees, double free, split and merge
    pending_requests.push_back(alloc_req(0));
    pending_requests.push_back(alloc_req(1));
    pending_requests.push_back(alloc_req(64));
    pending_requests.push_back(alloc_req(65));
    pending_requests.push_back(alloc_req(19'h7FFFF));
    pending_requests.push_back(alloc_req(262144));
    pending_requests.push_back(free_req(3 * ALIGN_BYTES));
    pending_requests.push_back(free_req(3 * ALIGN_BYTES));
    pending_requests.push_back(free_req(0));
    pending_requests.push_back(free_req(ALIGN_BYTES + 1));
    pending_requests.push_back(free_req(18'h3FFFF));
    pending_requests.push_back(free_req(18'h3FFC0));
    pending_requests.push_back(free_req(5 * ALIGN_BYTES));
    pending_requests.push_back(free_req(7 * ALIGN_BYTES));
    pending_requests.push_back(alloc_req(0));
    pending_requests.push_back(alloc_req(200000));
    pending_requests.push_back(alloc_req(100000));
    drain();

    // receiver holds off while requests keep coming
    hold_rsp = 1'b1;
    repeat (30) pending_requests.push_back(random_request(600));
    repeat (300) @(posedge clk_i);
    hold_rsp = 1'b0;
    drain();

    // sender pause until all results are in, then continue
    run_random(200, 800);
    foreach (arena_settings[k]) begin
      write_arena(arena_settings[k]);
      run_random(k == 1 ? 10 : 100, k == 2 ? 300 : 2000);
    end
    write_arena(262144);
    run_random(100, 19'h7FFFF);

    $display("%0d results checked, %0d failed allocations, arena sizes 0 to max",
             results_seen, fails_seen);
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

@@ files.f @@
design/ffaa_pkg.sv
design/ffaa_req_if.sv
design/ffaa_rsp_if.sv
design/ffaa_ram.sv
design/first_fit_arena_allocator.sv
design/ffaa_checker.sv
dv/first_fit_arena_allocator_tb.sv
